// ===== hdl/qdv_pkg.sv =====
// Shared types, widths and constants for the quadrature decoder with velocity.
// Used by the top level and by its port checker; depends on nothing else.
`timescale 1ns / 1ps

package qdv_pkg;

   // Field and register widths
   localparam int COUNT_W    = 32;
   localparam int TS_W       = 32;
   localparam int VEL_W      = 48;
   localparam int STEP_W     = 2;
   localparam int PPR_W      = 16;
   localparam int ALPHA_W    = 17;
   localparam int FRAC_W     = 16;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 17;

   // Shared multiplier: 32 x 17 bits, the magnitude is fed in 24-bit chunks
   localparam int MUL_A_W = 32;
   localparam int MUL_B_W = 17;
   localparam int MUL_P_W = MUL_A_W + MUL_B_W;
   localparam int CHUNK_W = 24;
   localparam int ACC_W   = MUL_P_W + CHUNK_W + 1;

   // 2*pi*1e6*65536, rounded: angle per count times microseconds, in Q.16
   localparam int                    SPEED_NUM_W = 39;
   localparam logic [SPEED_NUM_W-1:0] SPEED_NUM   = 39'd411774832291;

   localparam logic [ALPHA_W-1:0] ALPHA_ONE  = 17'd65536;
   localparam logic [FRAC_W-1:0]  ROUND_HALF = 16'd32768;

   // Reset values of the configuration registers
   localparam logic [PPR_W-1:0]   PPR_RESET   = 16'd1024;
   localparam logic [ALPHA_W-1:0] ALPHA_RESET = 17'd6554;

   // Operation codes of an input item
   localparam logic OP_SAMPLE = 1'b0;
   localparam logic OP_ZERO   = 1'b1;

   // Configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_INVERT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PPR    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ALPHA  = 2'd2;

   // Step codes
   localparam logic signed [STEP_W-1:0] STEP_NONE = 2'sb00;
   localparam logic signed [STEP_W-1:0] STEP_FWD  = 2'sb01;
   localparam logic signed [STEP_W-1:0] STEP_REV  = 2'sb11;

   // x4 transition table, indexed by previous levels then current levels (A high, B low).
   // Double-step transitions and no change give no step.
   function automatic logic signed [STEP_W-1:0] step_lookup(input logic [3:0] idx);
      logic signed [STEP_W-1:0] res;
      case (idx)
         4'd1, 4'd7, 4'd8, 4'd14: res = STEP_REV;
         4'd2, 4'd4, 4'd11, 4'd13: res = STEP_FWD;
         default: res = STEP_NONE;
      endcase
      return res;
   endfunction

endpackage

// ===== hdl/quadrature_decoder_velocity.sv =====
// Top level of the x4 quadrature decoder with filtered angular velocity.
// Depends on qdv_pkg; holds the sequencer, the shared multiplier and the divider.
`timescale 1ns / 1ps
//
//  Channel | Direction | Handshake             | Content
//  --------+-----------+-----------------------+------------------------------------------
//  req_    | in        | req_valid / req_stall | operation, levels A/B, timestamp (us)
//  rsp_    | out       | rsp_valid / rsp_stall | position count, velocity Q31.16, step
//  csr_    | in        | csr_write             | index 0 invert, 1 pulses/rev, 2 alpha
//
//  A zero operation, a sample without a step, or a step whose gap is out of range
//  gives its result in the cycle after acceptance.
//  A step with a valid gap goes on through the shared multiplier, the one-bit-per-cycle
//  restoring divider that forms the speed, and the alpha filter blend.
//  One item is in work at a time; req_stall is high while the sequencer is busy
//  and while a finished result waits on rsp_stall.
//  Reset is synchronous and active high; it restores the registers and clears state.

module quadrature_decoder_velocity
   import qdv_pkg::*;
#(
   parameter int MAX_GAP_US = 1000000,
   parameter int MIN_GAP_US = 100
) (
   input  logic                        clock,
   input  logic                        reset,
   // Input items
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic                        req_operation,
   input  logic                        req_level_a,
   input  logic                        req_level_b,
   input  logic [TS_W-1:0]             req_timestamp_us,
   // Result items
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic signed [COUNT_W-1:0]   rsp_position_count,
   output logic signed [VEL_W-1:0]     rsp_velocity,
   output logic signed [STEP_W-1:0]    rsp_step,
   // Configuration writes
   input  logic                        csr_write,
   input  logic [CSR_IDX_W-1:0]        csr_index,
   input  logic [CSR_DATA_W-1:0]       csr_data
);

   // Derived widths: the gap, the divisor, the dividend and the divider counter
   localparam int GAP_TOP = (MAX_GAP_US > MIN_GAP_US) ? MAX_GAP_US : MIN_GAP_US + 1;
   localparam int DT_W    = $clog2(GAP_TOP);
   localparam int DEN_W   = PPR_W + DT_W;
   localparam int NUM_W   = ((DEN_W - 1 > SPEED_NUM_W) ? DEN_W - 1 : SPEED_NUM_W) + 1;
   localparam int CNT_W   = $clog2(NUM_W);

   typedef enum logic [9:0] {
      S_IDLE    = 10'b00_0000_0001,
      S_MUL_DEN = 10'b00_0000_0010,
      S_PREP    = 10'b00_0000_0100,
      S_DIV     = 10'b00_0000_1000,
      S_DIFF    = 10'b00_0001_0000,
      S_MUL_LO  = 10'b00_0010_0000,
      S_MUL_HI  = 10'b00_0100_0000,
      S_ACC     = 10'b00_1000_0000,
      S_BLEND   = 10'b01_0000_0000,
      S_DONE    = 10'b10_0000_0000
   } state_type;

   // Control and model state
   state_type              state_ff, state_in;
   logic                   invert_ff, invert_in;
   logic [PPR_W-1:0]       ppr_ff, ppr_in;
   logic [ALPHA_W-1:0]     alpha_ff, alpha_in;
   logic [1:0]             prev_ff, prev_in;
   logic [COUNT_W-1:0]     count_ff, count_in;
   logic [TS_W-1:0]        last_time_ff, last_time_in;
   logic [VEL_W-1:0]       vel_ff, vel_in;
   logic                   rsp_valid_ff, rsp_valid_in;

   // Working registers of the sequencer
   logic [DT_W-1:0]        dt_ff, dt_in;
   logic                   step_neg_ff, step_neg_in;
   logic [STEP_W-1:0]      hold_step_ff, hold_step_in;
   logic [DEN_W-1:0]       den_ff, den_in;
   logic [DEN_W-1:0]       rem_ff, rem_in;
   logic [NUM_W-1:0]       num_ff, num_in;
   logic [CNT_W-1:0]       div_cnt_ff, div_cnt_in;
   logic                   diff_neg_ff, diff_neg_in;
   logic [VEL_W-1:0]       mag_ff, mag_in;
   logic [MUL_P_W-1:0]     prod_ff, prod_in;
   logic [ACC_W-1:0]       acc_ff, acc_in;

   // Result registers
   logic [COUNT_W-1:0]     out_count_ff, out_count_in;
   logic [VEL_W-1:0]       out_vel_ff, out_vel_in;
   logic [STEP_W-1:0]      out_step_ff, out_step_in;

   // Combinational helpers
   logic                       req_accept;
   logic                       out_free;
   logic [1:0]                 cur_levels;
   logic signed [STEP_W-1:0]   table_step;
   logic signed [STEP_W-1:0]   step_inv;
   logic [COUNT_W-1:0]         count_step;
   logic [TS_W-1:0]            dt_raw;
   logic                       dt_ok;
   logic [DT_W-1:0]            dt_clamp;
   logic [PPR_W-1:0]           ppr_eff;
   logic [ALPHA_W-1:0]         alpha_eff;
   logic [MUL_A_W-1:0]         mul_a;
   logic [MUL_B_W-1:0]         mul_b;
   logic [MUL_P_W-1:0]         mul_p;
   logic [DEN_W:0]             trial;
   logic [DEN_W:0]             trial_sub;
   logic [VEL_W-1:0]           inst_mag;
   logic [VEL_W-1:0]           inst_vel;
   logic [VEL_W:0]             diff;
   logic [VEL_W:0]             diff_abs;
   logic [VEL_W-1:0]           delta;

   // Handshake
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign req_stall  = (state_ff != S_IDLE) || !out_free;
   assign req_accept = req_valid && !req_stall;

   // Step decode and count update for the item on the input
   assign cur_levels = {req_level_a, req_level_b};
   assign table_step = step_lookup({prev_ff, cur_levels});
   assign step_inv   = invert_ff ? -table_step : table_step;
   assign count_step = count_ff + {{(COUNT_W - STEP_W){step_inv[STEP_W-1]}}, step_inv};

   // Gap since the last step, with the lower clamp
   assign dt_raw   = req_timestamp_us - last_time_ff;
   assign dt_ok    = (dt_raw != '0) && (dt_raw < TS_W'(MAX_GAP_US));
   assign dt_clamp = (dt_raw < TS_W'(MIN_GAP_US)) ? DT_W'(MIN_GAP_US) : dt_raw[DT_W-1:0];

   // Register values as the arithmetic uses them
   assign ppr_eff   = (ppr_ff == '0) ? PPR_W'(1) : ppr_ff;
   assign alpha_eff = (alpha_ff > ALPHA_ONE) ? ALPHA_ONE : alpha_ff;

   // Shared multiplier: gap times pulses, then the two chunks of the error times alpha
   always_comb begin
      unique case (state_ff)
         S_MUL_DEN: begin
            mul_a = MUL_A_W'(dt_ff);
            mul_b = MUL_B_W'(ppr_eff);
         end
         S_MUL_LO: begin
            mul_a = MUL_A_W'(mag_ff[CHUNK_W-1:0]);
            mul_b = alpha_eff;
         end
         S_MUL_HI: begin
            mul_a = MUL_A_W'(mag_ff[VEL_W-1:CHUNK_W]);
            mul_b = alpha_eff;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end
   assign mul_p = mul_a * mul_b;

   // Restoring divider step: one quotient bit per cycle
   assign trial     = {rem_ff, num_ff[NUM_W-1]};
   assign trial_sub = trial - {1'b0, den_ff};

   // Instantaneous speed with its sign, and the error against the filtered value
   assign inst_mag = VEL_W'(num_ff);
   assign inst_vel = step_neg_ff ? -inst_mag : inst_mag;
   assign diff     = {inst_vel[VEL_W-1], inst_vel} - {vel_ff[VEL_W-1], vel_ff};
   assign diff_abs = diff[VEL_W] ? -diff : diff;
   assign delta    = acc_ff[FRAC_W +: VEL_W];

   // Sequencer and state update
   always_comb begin
      state_in     = state_ff;
      invert_in    = invert_ff;
      ppr_in       = ppr_ff;
      alpha_in     = alpha_ff;
      prev_in      = prev_ff;
      count_in     = count_ff;
      last_time_in = last_time_ff;
      vel_in       = vel_ff;
      rsp_valid_in = rsp_valid_ff;
      dt_in        = dt_ff;
      step_neg_in  = step_neg_ff;
      hold_step_in = hold_step_ff;
      den_in       = den_ff;
      rem_in       = rem_ff;
      num_in       = num_ff;
      div_cnt_in   = div_cnt_ff;
      diff_neg_in  = diff_neg_ff;
      mag_in       = mag_ff;
      prod_in      = prod_ff;
      acc_in       = acc_ff;
      out_count_in = out_count_ff;
      out_vel_in   = out_vel_ff;
      out_step_in  = out_step_ff;

      // A result taken frees the output register
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      // Configuration writes; indexes beyond the list are ignored
      if (csr_write) begin
         unique case (csr_index)
            CSR_INVERT: invert_in = csr_data[0];
            CSR_PPR:    ppr_in    = csr_data[PPR_W-1:0];
            CSR_ALPHA:  alpha_in  = csr_data[ALPHA_W-1:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               if (req_operation == OP_ZERO) begin
                  count_in     = '0;
                  out_count_in = '0;
                  out_vel_in   = vel_ff;
                  out_step_in  = STEP_NONE;
                  rsp_valid_in = 1'b1;
               end else begin
                  prev_in = cur_levels;
                  if (table_step != STEP_NONE) begin
                     count_in     = count_step;
                     last_time_in = req_timestamp_us;
                     if (dt_ok) begin
                        dt_in        = dt_clamp;
                        step_neg_in  = step_inv[STEP_W-1];
                        hold_step_in = step_inv;
                        state_in     = S_MUL_DEN;
                     end else begin
                        out_count_in = count_step;
                        out_vel_in   = vel_ff;
                        out_step_in  = step_inv;
                        rsp_valid_in = 1'b1;
                     end
                  end else begin
                     out_count_in = count_ff;
                     out_vel_in   = vel_ff;
                     out_step_in  = STEP_NONE;
                     rsp_valid_in = 1'b1;
                  end
               end
            end
         end
         S_MUL_DEN: begin
            den_in   = mul_p[DEN_W-1:0];
            state_in = S_PREP;
         end
         S_PREP: begin
            // Dividend carries half the divisor so that the quotient rounds half up
            num_in     = NUM_W'(SPEED_NUM) + NUM_W'(den_ff >> 1);
            rem_in     = '0;
            div_cnt_in = CNT_W'(NUM_W - 1);
            state_in   = S_DIV;
         end
         S_DIV: begin
            if (!trial_sub[DEN_W]) begin
               rem_in = trial_sub[DEN_W-1:0];
               num_in = {num_ff[NUM_W-2:0], 1'b1};
            end else begin
               rem_in = trial[DEN_W-1:0];
               num_in = {num_ff[NUM_W-2:0], 1'b0};
            end
            if (div_cnt_ff == '0) begin
               state_in = S_DIFF;
            end else begin
               div_cnt_in = div_cnt_ff - CNT_W'(1);
            end
         end
         S_DIFF: begin
            diff_neg_in = diff[VEL_W];
            mag_in      = diff_abs[VEL_W-1:0];
            state_in    = S_MUL_LO;
         end
         S_MUL_LO: begin
            prod_in  = mul_p;
            state_in = S_MUL_HI;
         end
         S_MUL_HI: begin
            acc_in   = ACC_W'(prod_ff) + ACC_W'(ROUND_HALF);
            prod_in  = mul_p;
            state_in = S_ACC;
         end
         S_ACC: begin
            acc_in   = acc_ff + (ACC_W'(prod_ff) << CHUNK_W);
            state_in = S_BLEND;
         end
         S_BLEND: begin
            vel_in   = diff_neg_ff ? (vel_ff - delta) : (vel_ff + delta);
            state_in = S_DONE;
         end
         S_DONE: begin
            if (out_free) begin
               out_count_in = count_ff;
               out_vel_in   = vel_ff;
               out_step_in  = hold_step_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Control and model state, cleared by reset
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         invert_ff    <= 1'b0;
         ppr_ff       <= PPR_RESET;
         alpha_ff     <= ALPHA_RESET;
         prev_ff      <= '0;
         count_ff     <= '0;
         last_time_ff <= '0;
         vel_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         invert_ff    <= invert_in;
         ppr_ff       <= ppr_in;
         alpha_ff     <= alpha_in;
         prev_ff      <= prev_in;
         count_ff     <= count_in;
         last_time_ff <= last_time_in;
         vel_ff       <= vel_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Working and result registers
   always_ff @(posedge clock) begin
      dt_ff        <= dt_in;
      step_neg_ff  <= step_neg_in;
      hold_step_ff <= hold_step_in;
      den_ff       <= den_in;
      rem_ff       <= rem_in;
      num_ff       <= num_in;
      div_cnt_ff   <= div_cnt_in;
      diff_neg_ff  <= diff_neg_in;
      mag_ff       <= mag_in;
      prod_ff      <= prod_in;
      acc_ff       <= acc_in;
      out_count_ff <= out_count_in;
      out_vel_ff   <= out_vel_in;
      out_step_ff  <= out_step_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_position_count = out_count_ff;
   assign rsp_velocity       = out_vel_ff;
   assign rsp_step           = out_step_ff;

endmodule

// ===== hdl/qdv_checker.sv =====
// Port-level checker for the quadrature decoder, with the bind that attaches it.
// Depends on qdv_pkg and on the ports of quadrature_decoder_velocity.
`timescale 1ns / 1ps

module qdv_checker
   import qdv_pkg::*;
(
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_stall,
   input logic                       req_operation,
   input logic                       rsp_valid,
   input logic                       rsp_stall,
   input logic signed [COUNT_W-1:0]  rsp_position_count,
   input logic signed [VEL_W-1:0]    rsp_velocity,
   input logic signed [STEP_W-1:0]   rsp_step
);

   // A stalled result item keeps its payload.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=>
         $stable(rsp_position_count) && $stable(rsp_velocity) && $stable(rsp_step))
      else $error("stalled result item changed");

   // Reset leaves no result item pending.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result item valid after reset");

   // A zero operation gives its result in the next cycle with a cleared count and no step.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req_operation == OP_ZERO) |=>
         rsp_valid && (rsp_position_count == '0) && (rsp_step == STEP_NONE))
      else $error("zero operation result wrong");

   // While a result item is held back, no new item is taken.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |-> req_stall)
      else $error("item accepted while result stalled");

endmodule

bind quadrature_decoder_velocity qdv_checker u_qdv_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_valid),
   .req_stall          (req_stall),
   .req_operation      (req_operation),
   .rsp_valid          (rsp_valid),
   .rsp_stall          (rsp_stall),
   .rsp_position_count (rsp_position_count),
   .rsp_velocity       (rsp_velocity),
   .rsp_step           (rsp_step)
);
